FILE: src/icrt_pkg.sv
package icrt_pkg;

    localparam int TABLE_ENTRIES_DEF     = 64;
    localparam int INODES_PER_SECTOR_DEF = 16;
    localparam int INODE_BYTES_DEF       = 32;

    localparam int DEV_W    = 16;
    localparam int INO_W    = 12;
    localparam int CNT_W    = 8;
    localparam int SLOT_W   = 6;
    localparam int SECTOR_W = 11;
    localparam int OFFSET_W = 9;
    localparam int STATUS_W = 3;
    localparam int IMAP_W   = 5;
    localparam int SMAP_W   = 11;
    localparam int CFG_W    = 11;

    // boot sector plus super block
    localparam int LEADING_SECTORS = 1 + 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

    localparam logic [1:0] ACT_GET     = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_LOCATE  = 2'd2;

    localparam logic [0:0] CFG_IMAP = 1'b0;
    localparam logic [0:0] CFG_SMAP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INODE0    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

    typedef struct packed {
        logic [DEV_W-1:0] device;
        logic [INO_W-1:0] inode;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [OFFSET_W-1:0] offset;
    } addr_t;

endpackage

FILE: src/icrt_addr_unit.sv
// Inode disk address: sector and byte offset of inode ino. The quotient of
// (ino - 1) by the inodes-per-sector count comes from a multiply by a fixed
// reciprocal, exact over the whole inode range; the remainder follows from
// one multiply and subtract. done pulses once the remainder is registered.
module icrt_addr_unit #(
    parameter int INODES_PER_SECTOR = icrt_pkg::INODES_PER_SECTOR_DEF,
    parameter int INODE_BYTES       = icrt_pkg::INODE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [icrt_pkg::INO_W-1:0]  dividend,
    input  logic [icrt_pkg::IMAP_W-1:0] imap,
    input  logic [icrt_pkg::SMAP_W-1:0] smap,
    output logic                        done,
    output icrt_pkg::addr_t             addr
);
    import icrt_pkg::*;

    localparam int     SHIFT  = INO_W + $clog2(INODES_PER_SECTOR);
    localparam int     PROD_W = SHIFT + INO_W;
    localparam longint RECIP  = ((longint'(1) << SHIFT) + longint'(INODES_PER_SECTOR) - 1)
                                / longint'(INODES_PER_SECTOR);
    localparam int     RMW    = $clog2(INODES_PER_SECTOR + 1);

    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_QUO  = 2'd1;
    localparam logic [1:0] STEP_REM  = 2'd2;

    logic [1:0]        step_reg;
    logic              done_reg;
    logic [INO_W-1:0]  idx_reg;
    logic [INO_W-1:0]  quo_reg;
    logic [RMW-1:0]    rem_reg;

    logic [PROD_W-1:0] quo_prod;
    logic [INO_W-1:0]  quo_times_div;
    logic [INO_W-1:0]  rem_full;
    logic [12:0]       sector_sum;
    logic [15:0]       offset_prod;

    assign quo_prod      = PROD_W'(idx_reg) * PROD_W'(RECIP);
    assign quo_times_div = quo_reg * INO_W'(INODES_PER_SECTOR);
    assign rem_full      = idx_reg - quo_times_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == STEP_REM);
            case (step_reg)
                STEP_IDLE:
                begin
                    if (start)
                    begin
                        step_reg <= STEP_QUO;
                    end
                end
                STEP_QUO: step_reg <= STEP_REM;
                STEP_REM: step_reg <= STEP_IDLE;
                default:  step_reg <= STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            idx_reg <= dividend;
        end
        if (step_reg == STEP_QUO)
        begin
            quo_reg <= quo_prod[SHIFT +: INO_W];
        end
        if (step_reg == STEP_REM)
        begin
            rem_reg <= rem_full[RMW-1:0];
        end
    end

    assign sector_sum  = 13'(LEADING_SECTORS) + 13'(imap) + 13'(smap) + 13'(quo_reg);
    assign offset_prod = 16'(rem_reg) * 16'(INODE_BYTES);

    assign done        = done_reg;
    assign addr.sector = sector_sum[SECTOR_W-1:0];
    assign addr.offset = offset_prod[OFFSET_W-1:0];

endmodule

FILE: src/inode_cache_refcount_table_top.sv
// Inode cache reference-count table.
// Input channel (in_valid/in_stall) carries one request: get, release or
// locate. Output channel (out_valid/out_stall) returns exactly one result
// per request. Configuration writes on cfg_we/cfg_index/cfg_data set the
// inode-map and sector-map sizes; the user must make them only while idle,
// as the block does not enforce it. One request is worked at a time;
// in_stall is high from transfer until the result is in the output register.
// Path from transfer to out_valid: a get hit scans up to the matching
// slot and updates it; a get with the table full scans every slot; a get
// miss claiming a slot scans every slot, then runs the address unit; a
// release or a locate of a free slot only evaluates the slot; a locate of
// a used slot evaluates it, then runs the address unit; inode zero, an
// unknown action or a slot beyond the table go straight to the output.
// The scan reads the entry memory one slot per cycle through its single
// read port; the next request can be taken in the cycle after a result loads.
// The output register holds a result while out_stall is high, and the
// next request is accepted meanwhile; it finishes once the register frees.
// Reset clears the reference counts (every slot free) through per-slot
// valid bits, sets both map sizes to 1, and leaves the block idle.
module inode_cache_refcount_table_top #(
    parameter int TABLE_ENTRIES     = icrt_pkg::TABLE_ENTRIES_DEF,
    parameter int INODES_PER_SECTOR = icrt_pkg::INODES_PER_SECTOR_DEF,
    parameter int INODE_BYTES       = icrt_pkg::INODE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [icrt_pkg::DEV_W-1:0]    device,
    input  logic [icrt_pkg::INO_W-1:0]    inode_number,
    input  logic [icrt_pkg::SLOT_W-1:0]   target_slot,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [icrt_pkg::SLOT_W-1:0]   slot_index,
    output logic                          hit,
    output logic                          fetch_needed,
    output logic [icrt_pkg::SECTOR_W-1:0] sector_number,
    output logic [icrt_pkg::OFFSET_W-1:0] byte_offset,
    output logic [icrt_pkg::STATUS_W-1:0] status,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [icrt_pkg::CFG_W-1:0]    cfg_data
);
    import icrt_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_GUPD = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_ADDR = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [IMAP_W-1:0] imap_reg;
    logic [SMAP_W-1:0] smap_reg;

    // request
    logic [1:0]        act_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [INO_W-1:0]  ino_reg;
    logic [IW-1:0]     tgt_reg;

    // entry memory, counts qualified by per-slot valid bits
    entry_t                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    entry_t                   rd_reg;
    logic                     rd_valid_reg;
    logic [IW-1:0]            raddr;
    logic                     mem_we;
    logic [IW-1:0]            waddr;
    entry_t                   wdata;
    logic                     rd_used;

    // scan pipeline
    logic          issue_on_reg;
    logic [IW-1:0] issue_idx_reg;
    logic          cmp_v_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          found_reg;
    logic          have_free_reg;
    logic [IW-1:0] free_reg;
    logic [IW-1:0] hit_idx_reg;
    entry_t        hit_ent_reg;

    // pending result
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_hit_reg;
    logic                res_fetch_reg;
    logic [SECTOR_W-1:0] res_sector_reg;
    logic [OFFSET_W-1:0] res_offset_reg;
    logic [STATUS_W-1:0] res_status_reg;

    // output register
    logic                out_valid_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_hit_reg;
    logic                out_fetch_reg;
    logic [SECTOR_W-1:0] out_sector_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                in_xfer;
    logic                out_load;
    logic                au_start;
    logic [INO_W-1:0]    au_dividend;
    logic                au_done;
    addr_t               au_addr;
    logic                tgt_in_range;
    logic                match;
    logic [STATUS_W-1:0] in_status;

    assign in_xfer      = in_valid && (state_reg == S_IDLE);
    assign in_stall     = (state_reg != S_IDLE);
    assign out_load     = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign tgt_in_range = (32'(target_slot) < TABLE_ENTRIES);
    assign rd_used      = rd_valid_reg && (rd_reg.count != '0);
    assign match        = (rd_reg.device == dev_reg) && (rd_reg.inode == ino_reg);

    assign raddr = (state_reg == S_IDLE) ? IW'(target_slot) : issue_idx_reg;

    // status known at the input transfer
    always_comb
    begin
        in_status = ST_OK;
        case (action)
            ACT_GET:
            begin
                if (inode_number == '0)
                begin
                    in_status = ST_INODE0;
                end
            end
            ACT_RELEASE, ACT_LOCATE:
            begin
                if (!tgt_in_range)
                begin
                    in_status = ST_UNUSED;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imap_reg <= IMAP_W'(1);
            smap_reg <= SMAP_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAP: imap_reg <= cfg_data[IMAP_W-1:0];
                CFG_SMAP: smap_reg <= cfg_data[SMAP_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[raddr];
            if (mem_we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mem_we      = 1'b0;
        waddr       = free_reg;
        wdata       = rd_reg;
        au_start    = 1'b0;
        au_dividend = ino_reg - INO_W'(1);
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (action)
                        ACT_GET:     state_next = (inode_number == '0) ? S_OUT : S_SCAN;
                        ACT_RELEASE: state_next = tgt_in_range ? S_EVAL : S_OUT;
                        ACT_LOCATE:  state_next = tgt_in_range ? S_EVAL : S_OUT;
                        default:     state_next = S_OUT;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cmp_v_reg && ((rd_used && match) || cmp_idx_reg == LAST_IDX))
                begin
                    state_next = S_GUPD;
                end
            end
            S_GUPD:
            begin
                if (found_reg)
                begin
                    waddr = hit_idx_reg;
                    wdata = hit_ent_reg;
                    wdata.count = hit_ent_reg.count + CNT_W'(1);
                    mem_we = (hit_ent_reg.count != COUNT_MAX);
                    state_next = S_OUT;
                end
                else if (!have_free_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mem_we       = 1'b1;
                    waddr        = free_reg;
                    wdata.device = dev_reg;
                    wdata.inode  = ino_reg;
                    wdata.count  = CNT_W'(1);
                    au_start     = 1'b1;
                    state_next   = S_ADDR;
                end
            end
            S_EVAL:
            begin
                waddr       = tgt_reg;
                wdata       = rd_reg;
                wdata.count = rd_reg.count - CNT_W'(1);
                au_dividend = rd_reg.inode - INO_W'(1);
                if (!rd_used)
                begin
                    state_next = S_OUT;
                end
                else if (act_reg == ACT_RELEASE)
                begin
                    mem_we     = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    au_start   = 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                if (au_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_on_reg  <= 1'b0;
            issue_idx_reg <= '0;
            cmp_v_reg     <= 1'b0;
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmp_v_reg <= (state_reg == S_SCAN) && issue_on_reg;
            if (in_xfer)
            begin
                issue_on_reg  <= 1'b1;
                issue_idx_reg <= '0;
                found_reg     <= 1'b0;
                have_free_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                if (issue_on_reg)
                begin
                    issue_idx_reg <= issue_idx_reg + IW'(1);
                end
                // stop issuing after the last slot or on a match
                if ((issue_on_reg && issue_idx_reg == LAST_IDX)
                    || (cmp_v_reg && rd_used && match))
                begin
                    issue_on_reg <= 1'b0;
                end
                if (cmp_v_reg)
                begin
                    if (rd_used && match)
                    begin
                        found_reg <= 1'b1;
                    end
                    else if (!rd_used && !have_free_reg)
                    begin
                        have_free_reg <= 1'b1;
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= issue_idx_reg;
        if (in_xfer)
        begin
            act_reg        <= action;
            dev_reg        <= device;
            ino_reg        <= inode_number;
            tgt_reg        <= IW'(target_slot);
            res_hit_reg    <= 1'b0;
            res_fetch_reg  <= 1'b0;
            res_sector_reg <= '0;
            res_offset_reg <= '0;
            res_slot_reg   <= (action inside {ACT_RELEASE, ACT_LOCATE}) ? target_slot : '0;
            res_status_reg <= in_status;
        end
        if (state_reg == S_SCAN && cmp_v_reg)
        begin
            if (rd_used && match)
            begin
                hit_idx_reg <= cmp_idx_reg;
                hit_ent_reg <= rd_reg;
            end
            else if (!rd_used && !have_free_reg)
            begin
                free_reg <= cmp_idx_reg;
            end
        end
        if (state_reg == S_GUPD)
        begin
            if (found_reg)
            begin
                res_slot_reg <= SLOT_W'(hit_idx_reg);
                res_hit_reg  <= 1'b1;
                if (hit_ent_reg.count == COUNT_MAX)
                begin
                    res_status_reg <= ST_SATURATED;
                end
            end
            else if (!have_free_reg)
            begin
                res_status_reg <= ST_FULL;
            end
            else
            begin
                res_slot_reg  <= SLOT_W'(free_reg);
                res_fetch_reg <= 1'b1;
            end
        end
        if (state_reg == S_EVAL && !rd_used)
        begin
            res_status_reg <= ST_UNUSED;
        end
        if (state_reg == S_ADDR && au_done)
        begin
            res_sector_reg <= au_addr.sector;
            res_offset_reg <= au_addr.offset;
        end
        if (out_load)
        begin
            out_slot_reg   <= res_slot_reg;
            out_hit_reg    <= res_hit_reg;
            out_fetch_reg  <= res_fetch_reg;
            out_sector_reg <= res_sector_reg;
            out_offset_reg <= res_offset_reg;
            out_status_reg <= res_status_reg;
        end
    end

    icrt_addr_unit #(
        .INODES_PER_SECTOR (INODES_PER_SECTOR),
        .INODE_BYTES       (INODE_BYTES)
    ) u_addr (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (au_start),
        .dividend (au_dividend),
        .imap     (imap_reg),
        .smap     (smap_reg),
        .done     (au_done),
        .addr     (au_addr)
    );

    assign out_valid     = out_valid_reg;
    assign slot_index    = out_slot_reg;
    assign hit           = out_hit_reg;
    assign fetch_needed  = out_fetch_reg;
    assign sector_number = out_sector_reg;
    assign byte_offset   = out_offset_reg;
    assign status        = out_status_reg;

endmodule

FILE: src/icrt_checker.sv
module icrt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [icrt_pkg::SLOT_W-1:0]   slot_index,
    input logic                          hit,
    input logic                          fetch_needed,
    input logic [icrt_pkg::SECTOR_W-1:0] sector_number,
    input logic [icrt_pkg::OFFSET_W-1:0] byte_offset,
    input logic [icrt_pkg::STATUS_W-1:0] status
);
    import icrt_pkg::*;

    // a held result keeps its status, slot index and address
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_index)
            && $stable(sector_number) && $stable(byte_offset))
        else $error("stalled result changed");

    // one request at a time: busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in progress");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !fetch_needed && (status == ST_OK || status == ST_SATURATED))
        else $error("hit with bad status or fetch");

    a_fetch_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fetch_needed |-> status == ST_OK)
        else $error("fetch with error status");

    a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> sector_number == '0 && byte_offset == '0)
        else $error("address on an error result");

endmodule

bind inode_cache_refcount_table_top icrt_checker u_icrt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot_index    (slot_index),
    .hit           (hit),
    .fetch_needed  (fetch_needed),
    .sector_number (sector_number),
    .byte_offset   (byte_offset),
    .status        (status)
);

FILE: tb/inode_cache_refcount_table_top_tb.sv
module inode_cache_refcount_table_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import icrt_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 11;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES_DEF + 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 225;
    localparam int MAX_REPORTS   = 40;

    localparam logic [DEV_W-1:0] DEV_POOL [4] = '{16'h0000, 16'hFFFF, 16'h0801, 16'h5A3C};

    typedef struct packed {
        logic [1:0]        action;
        logic [DEV_W-1:0]  device;
        logic [INO_W-1:0]  inode;
        logic [SLOT_W-1:0] slot;
    } request_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                fetch;
        logic [SECTOR_W-1:0] sector;
        logic [OFFSET_W-1:0] offset;
        logic [STATUS_W-1:0] status;
    } result_t;

    class refcount_scoreboard;
        logic [DEV_W-1:0]  dev_tab [TABLE_ENTRIES_DEF];
        logic [INO_W-1:0]  ino_tab [TABLE_ENTRIES_DEF];
        logic [CNT_W-1:0]  cnt_tab [TABLE_ENTRIES_DEF];
        logic [IMAP_W-1:0] imap_sectors;
        logic [SMAP_W-1:0] smap_sectors;
        result_t           pending_results [$];
        int errors;
        int n_get, n_hit, n_fetch, n_full, n_sat, n_inode0;
        int n_release, n_locate, n_unknown, n_unused;

        function new();
            foreach (cnt_tab[i])
            begin
                dev_tab[i] = '0;
                ino_tab[i] = '0;
                cnt_tab[i] = '0;
            end
            imap_sectors = IMAP_W'(1);
            smap_sectors = SMAP_W'(1);
        endfunction

        function void inode_location(input logic [INO_W-1:0] ino,
                                     output logic [SECTOR_W-1:0] sec,
                                     output logic [OFFSET_W-1:0] off);
            int idx;
            int s;
            int o;
            idx = (int'(ino) - 1) & 'hFFF;
            s = LEADING_SECTORS + int'(imap_sectors) + int'(smap_sectors)
                + idx / INODES_PER_SECTOR_DEF;
            o = (idx % INODES_PER_SECTOR_DEF) * INODE_BYTES_DEF;
            sec = s[SECTOR_W-1:0];
            off = o[OFFSET_W-1:0];
        endfunction

        // updates the cached table and returns the answer to one request
        function result_t apply_request(request_t rq);
            result_t r;
            int found_slot;
            int free_slot;
            r = '0;
            found_slot = -1;
            free_slot = -1;
            case (rq.action)
                ACT_GET:
                begin
                    if (rq.inode == '0)
                        r.status = ST_INODE0;
                    else
                    begin
                        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
                        begin
                            if (found_slot < 0)
                            begin
                                if (cnt_tab[i] != '0)
                                begin
                                    if (dev_tab[i] == rq.device && ino_tab[i] == rq.inode)
                                        found_slot = i;
                                end
                                else if (free_slot < 0)
                                    free_slot = i;
                            end
                        end
                        if (found_slot >= 0)
                        begin
                            r.slot = found_slot[SLOT_W-1:0];
                            r.hit = 1'b1;
                            if (cnt_tab[found_slot] == COUNT_MAX)
                                r.status = ST_SATURATED;
                            else
                                cnt_tab[found_slot] = cnt_tab[found_slot] + CNT_W'(1);
                        end
                        else if (free_slot < 0)
                            r.status = ST_FULL;
                        else
                        begin
                            dev_tab[free_slot] = rq.device;
                            ino_tab[free_slot] = rq.inode;
                            cnt_tab[free_slot] = CNT_W'(1);
                            r.slot = free_slot[SLOT_W-1:0];
                            r.fetch = 1'b1;
                            inode_location(rq.inode, r.sector, r.offset);
                        end
                    end
                end
                ACT_RELEASE, ACT_LOCATE:
                begin
                    r.slot = rq.slot;
                    if (int'(rq.slot) >= TABLE_ENTRIES_DEF || cnt_tab[rq.slot] == '0)
                        r.status = ST_UNUSED;
                    else if (rq.action == ACT_RELEASE)
                        cnt_tab[rq.slot] = cnt_tab[rq.slot] - CNT_W'(1);
                    else
                        inode_location(ino_tab[rq.slot], r.sector, r.offset);
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(request_t rq);
            result_t r;
            r = apply_request(rq);
            pending_results.push_back(r);
            case (rq.action)
                ACT_GET:     n_get++;
                ACT_RELEASE: n_release++;
                ACT_LOCATE:  n_locate++;
                default:     n_unknown++;
            endcase
            if (r.hit)
                n_hit++;
            if (r.fetch)
                n_fetch++;
            case (r.status)
                ST_FULL:      n_full++;
                ST_SATURATED: n_sat++;
                ST_INODE0:    n_inode0++;
                ST_UNUSED:    n_unused++;
                default: ;
            endcase
        endfunction

        function int pick_used_slot();
            int used [$];
            foreach (cnt_tab[i])
                if (cnt_tab[i] != '0)
                    used.push_back(i);
            if (used.size() == 0)
                return -1;
            return used[$urandom_range(0, used.size() - 1)];
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("unexpected result transfer: slot_index %0d status %0d",
                           got.slot, got.status);
                return;
            end
            want = pending_results.pop_front();
            compare_field("slot_index", want.slot, got.slot);
            compare_field("hit", want.hit, got.hit);
            compare_field("fetch_needed", want.fetch, got.fetch);
            compare_field("sector_number", want.sector, got.sector);
            compare_field("byte_offset", want.offset, got.offset);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [1:0]          action       = '0;
    logic [DEV_W-1:0]    device       = '0;
    logic [INO_W-1:0]    inode_number = '0;
    logic [SLOT_W-1:0]   target_slot  = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [SLOT_W-1:0]   slot_index;
    logic                hit;
    logic                fetch_needed;
    logic [SECTOR_W-1:0] sector_number;
    logic [OFFSET_W-1:0] byte_offset;
    logic [STATUS_W-1:0] status;
    logic                cfg_we       = 1'b0;
    logic [0:0]          cfg_index    = '0;
    logic [CFG_W-1:0]    cfg_data     = '0;

    refcount_scoreboard sb;
    bit                 idle_on = 1'b1;
    bit                 hold_request = 1'b0;
    int                 cycle_count = 0;

    inode_cache_refcount_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .device       (device),
        .inode_number (inode_number),
        .target_slot  (target_slot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot_index   (slot_index),
        .hit          (hit),
        .fetch_needed (fetch_needed),
        .sector_number(sector_number),
        .byte_offset  (byte_offset),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // both channels sampled at the edge, before any of this edge's updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result('{slot_index, hit, fetch_needed, sector_number,
                                  byte_offset, status});
            if (in_valid && !in_stall)
                sb.note_request('{action, device, inode_number, target_slot});
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [DEV_W-1:0] dev,
                                input logic [INO_W-1:0] ino, input logic [SLOT_W-1:0] slot);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        device       <= dev;
        inode_number <= ino;
        target_slot  <= slot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random(input int get_pct);
        logic [DEV_W-1:0]  dev;
        logic [INO_W-1:0]  ino;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        act;
        int sub;
        int used;
        if ($urandom_range(0, 99) < get_pct)
        begin
            sub = $urandom_range(0, 99);
            if (sub < 5)
            begin
                dev = 16'($urandom);
                ino = '0;
            end
            else if (sub < 80)
            begin
                // small pool so that hits and a full table are common
                dev = DEV_POOL[$urandom_range(0, 3)];
                ino = 12'($urandom_range(1, 48));
            end
            else
            begin
                dev = 16'($urandom);
                ino = 12'($urandom_range(1, 4095));
            end
            send_request(ACT_GET, dev, ino, 6'($urandom));
        end
        else
        begin
            sub = $urandom_range(0, 99);
            used = sb.pick_used_slot();
            if (used >= 0 && $urandom_range(0, 99) < 85)
                slot = used[SLOT_W-1:0];
            else
                slot = 6'($urandom_range(0, 63));
            if (sub < 55)
                act = ACT_RELEASE;
            else if (sub < 90)
                act = ACT_LOCATE;
            else
                act = ACT_UNKNOWN;
            send_request(act, 16'($urandom), 12'($urandom), slot);
        end
    endtask

    task automatic wait_idle();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // called only with the block idle and in_valid already low
    task automatic program_maps(input int imap, input int smap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAP;
        cfg_data  <= CFG_W'(imap);
        @(posedge clk);
        cfg_index <= CFG_SMAP;
        cfg_data  <= CFG_W'(smap);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.imap_sectors = imap[IMAP_W-1:0];
        sb.smap_sectors = smap[SMAP_W-1:0];
    endtask

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset map sizes
        send_request(ACT_GET, 16'h0000, 12'h000, 6'h3F);
        send_request(ACT_GET, 16'hFFFF, 12'hFFF, 6'h00);
        send_request(ACT_GET, 16'hFFFF, 12'hFFF, 6'h3F);
        send_request(ACT_GET, 16'h0000, 12'h001, 6'h00);
        send_request(ACT_GET, 16'hFFFF, 12'h001, 6'h00);
        send_request(ACT_LOCATE, 16'h0000, 12'h000, 6'd0);
        send_request(ACT_LOCATE, 16'h0000, 12'h000, 6'd63);
        send_request(ACT_RELEASE, 16'h0000, 12'h000, 6'd63);
        send_request(ACT_RELEASE, 16'hFFFF, 12'hFFF, 6'd0);
        send_request(ACT_RELEASE, 16'h0000, 12'h000, 6'd0);
        send_request(ACT_RELEASE, 16'h0000, 12'h000, 6'd0);
        send_request(ACT_LOCATE, 16'h0000, 12'h000, 6'd0);
        send_request(ACT_UNKNOWN, 16'hFFFF, 12'hFFF, 6'h3F);
        send_request(ACT_GET, 16'hFFFF, 12'hFFF, 6'h00);
        send_request(ACT_GET, 16'h0000, 12'd16, 6'h00);
        send_request(ACT_GET, 16'h0000, 12'd17, 6'h00);
        send_request(ACT_LOCATE, 16'h0000, 12'h000, 6'd1);
        send_request(ACT_RELEASE, 16'h0000, 12'h000, 6'd2);

        // one entry driven past the count limit
        for (int i = 0; i < 258; i++)
            send_request(ACT_GET, 16'hA5A5, 12'h7FF, 6'($urandom));

        // largest map sizes: fill the table past full, then locate every slot
        in_valid <= 1'b0;
        wait_idle();
        program_maps(16, 1024);
        for (int i = 0; i < 70; i++)
            send_request(ACT_GET, 16'h3C3C, 12'(200 + i), 6'($urandom));
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            send_request(ACT_LOCATE, 16'($urandom), 12'($urandom), 6'(i));

        for (int phase = 0; phase < 6; phase++)
        begin
            in_valid <= 1'b0;
            wait_idle();
            case (phase)
                0: program_maps(1, 1024);
                1: program_maps(16, 1);
                2: program_maps(1, 1);
                3: program_maps(16, 1024);
                default: program_maps($urandom_range(1, 16), $urandom_range(1, 1024));
            endcase
            // phase 3 runs with no idling on either side
            idle_on = (phase != 3);
            if (phase == 2)
                hold_request = 1'b1;
            // alternate filling and draining the table
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random((phase % 2 == 0) ? 65 : 30);
        end
        in_valid <= 1'b0;
        wait_idle();

        $display("Covered %0d gets: %0d hits, %0d fetches, %0d table full,",
                 sb.n_get, sb.n_hit, sb.n_fetch, sb.n_full);
        $display("%0d saturated, %0d inode zero; %0d releases, %0d locates, %0d unknown, %0d unused.",
                 sb.n_sat, sb.n_inode0, sb.n_release, sb.n_locate, sb.n_unknown, sb.n_unused);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/icrt_pkg.sv
src/icrt_addr_unit.sv
src/inode_cache_refcount_table_top.sv
src/icrt_checker.sv
tb/inode_cache_refcount_table_top_tb.sv
